>>> hw/rtl/ogrc_pkg.sv
// ----------------------------------------------------------------------------
// ogrc_pkg
// Shared types and constants of the occupancy grid region check block:
// field widths, request codes, register map, configuration bundle and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ogrc_pkg;

    // default sizes of the grid storage
    localparam int DEF_MAX_COLUMNS   = 64;
    localparam int DEF_MAX_ROWS      = 64;
    localparam int DEF_CATEGORY_BITS = 16;

    // field widths of the stream payload
    localparam int REQ_W    = 3;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 7;
    localparam int CAT_W    = 16;
    localparam int SIZE_W   = 12;
    localparam int CELL_W_W = 11;
    localparam int MAP_W    = 7;

    // pixel coordinates: 7-bit cell index times 11-bit cell size plus a 12-bit box size
    localparam int PIX_W = 19;

    // stream bus widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 24;

    // register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [CELL_W_W-1:0] RST_CELL_WIDTH  = CELL_W_W'(32);
    localparam logic [CELL_W_W-1:0] RST_CELL_HEIGHT = CELL_W_W'(32);
    localparam logic [MAP_W-1:0]    RST_MAP_COLUMNS = MAP_W'(64);
    localparam logic [MAP_W-1:0]    RST_MAP_ROWS    = MAP_W'(64);

    // register index (byte address divided by four)
    typedef enum logic [1:0] {
        REG_CELL_WIDTH  = 2'd0,
        REG_CELL_HEIGHT = 2'd1,
        REG_MAP_COLUMNS = 2'd2,
        REG_MAP_ROWS    = 2'd3
    } reg_idx_t;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_MARK   = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_CLEAR  = 3'd2,
        REQ_QUERY  = 3'd3,
        REQ_BOX    = 3'd4
    } req_type_t;

    // configuration bundle
    typedef struct packed {
        logic [CELL_W_W-1:0] cell_width;
        logic [CELL_W_W-1:0] cell_height;
        logic [MAP_W-1:0]    map_columns;
        logic [MAP_W-1:0]    map_rows;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;      // load the accepted request
        logic clr_start;    // restart the clearing sweep
        logic clr_step;     // write one zero entry of the sweep
        logic wr_mark;      // write back a marked cell
        logic wr_del;       // write back an empty cell
        logic set_cell_res; // take the read cell into the result
        logic set_free;     // result reports free
        logic box_mul;      // box start pixels
        logic box_end;      // box end pixels
        logic box_rd;       // read the walk cell
        logic box_adv;      // step the walk
        logic out_load;     // move the result to the output register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        req_type_t req;
        logic      in_map;
        logic      small_box;
        logic      rd_marked;
        logic      clr_last;
        logic      col_more;
        logic      row_more;
        logic      out_free;
    } stat_t;

endpackage

>>> hw/rtl/ogrc_ram.sv
// ----------------------------------------------------------------------------
// ogrc_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module ogrc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/ogrc_cfg.sv
// ----------------------------------------------------------------------------
// ogrc_cfg
// Configuration registers behind the APB-style port: cell size and map size.
// ----------------------------------------------------------------------------
module ogrc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ogrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ogrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ogrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output ogrc_pkg::cfg_t                  cfg
);

    import ogrc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width  <= RST_CELL_WIDTH;
            cfg_reg.cell_height <= RST_CELL_HEIGHT;
            cfg_reg.map_columns <= RST_MAP_COLUMNS;
            cfg_reg.map_rows    <= RST_MAP_ROWS;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CELL_WIDTH:  cfg_reg.cell_width  <= pwdata[CELL_W_W-1:0];
                REG_CELL_HEIGHT: cfg_reg.cell_height <= pwdata[CELL_W_W-1:0];
                REG_MAP_COLUMNS: cfg_reg.map_columns <= pwdata[MAP_W-1:0];
                REG_MAP_ROWS:    cfg_reg.map_rows    <= pwdata[MAP_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_CELL_WIDTH:  prdata = APB_DATA_W'(cfg_reg.cell_width);
            REG_CELL_HEIGHT: prdata = APB_DATA_W'(cfg_reg.cell_height);
            REG_MAP_COLUMNS: prdata = APB_DATA_W'(cfg_reg.map_columns);
            REG_MAP_ROWS:    prdata = APB_DATA_W'(cfg_reg.map_rows);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/ogrc_ctrl.sv
// ----------------------------------------------------------------------------
// ogrc_ctrl
// Request sequencer: decodes each request and steps the datapath through
// the read, write back, clearing sweep and box walk.
// ----------------------------------------------------------------------------
module ogrc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  ogrc_pkg::stat_t stat,
    output ogrc_pkg::cmd_t  cmd
);

    import ogrc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_UPDATE,
        ST_DEL_WR,
        ST_CLEAR,
        ST_BOX_MUL,
        ST_BOX_END,
        ST_BOX_RD,
        ST_BOX_CHK,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   clr_pend_reg;
    logic   clr_pend_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        clr_pend_next = clr_pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.req)
                    REQ_MARK, REQ_QUERY:
                    begin
                        state_next = stat.in_map ? ST_READ : ST_RESP;
                    end
                    REQ_DELETE:
                    begin
                        state_next = stat.in_map ? ST_DEL_WR : ST_RESP;
                    end
                    REQ_CLEAR:
                    begin
                        cmd.clr_start = 1'b1;
                        clr_pend_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    REQ_BOX:
                    begin
                        if (!stat.in_map)
                        begin
                            state_next = ST_RESP;
                        end
                        else if (stat.small_box)
                        begin
                            cmd.set_free = 1'b1;
                            state_next   = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_BOX_MUL;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (stat.req == REQ_MARK)
                begin
                    cmd.wr_mark = 1'b1;
                end
                else
                begin
                    cmd.set_cell_res = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_DEL_WR:
            begin
                cmd.wr_del = 1'b1;
                state_next = ST_RESP;
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    clr_pend_next = 1'b0;
                    state_next    = clr_pend_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_BOX_MUL:
            begin
                cmd.box_mul = 1'b1;
                state_next  = ST_BOX_END;
            end
            ST_BOX_END:
            begin
                cmd.box_end = 1'b1;
                state_next  = ST_BOX_RD;
            end
            ST_BOX_RD:
            begin
                cmd.box_rd = 1'b1;
                state_next = ST_BOX_CHK;
            end
            ST_BOX_CHK:
            begin
                if (stat.rd_marked)
                begin
                    state_next = ST_RESP;
                end
                else if (stat.col_more || stat.row_more)
                begin
                    cmd.box_adv = 1'b1;
                    state_next  = ST_BOX_RD;
                end
                else
                begin
                    cmd.set_free = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register, clearing sweep runs after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

endmodule

>>> hw/rtl/ogrc_dp.sv
// ----------------------------------------------------------------------------
// ogrc_dp
// Datapath: request registers, grid memory with its address and write data,
// clearing counter, box walk coordinates and the result and output registers.
// ----------------------------------------------------------------------------
module ogrc_dp #(
    parameter int MAX_COLUMNS   = ogrc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = ogrc_pkg::DEF_MAX_ROWS,
    parameter int CATEGORY_BITS = ogrc_pkg::DEF_CATEGORY_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ogrc_pkg::cfg_t                cfg,
    input  logic [ogrc_pkg::REQ_W-1:0]    req_type,
    input  logic [ogrc_pkg::COL_W-1:0]    cell_col,
    input  logic [ogrc_pkg::ROW_W-1:0]    cell_row,
    input  logic [ogrc_pkg::CAT_W-1:0]    category,
    input  logic                          replace_category,
    input  logic [ogrc_pkg::SIZE_W-1:0]   box_width,
    input  logic [ogrc_pkg::SIZE_W-1:0]   box_height,
    input  ogrc_pkg::cmd_t                cmd,
    output ogrc_pkg::stat_t               stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          is_free,
    output logic                          is_marked,
    output logic [ogrc_pkg::CAT_W-1:0]    stored_category
);

    import ogrc_pkg::*;

    localparam int DEPTH     = MAX_COLUMNS * MAX_ROWS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_W     = CATEGORY_BITS + 1;
    localparam int MAP_MAX   = (1 << MAP_W) - 1;
    localparam int COLS_CLIP = (MAX_COLUMNS > MAP_MAX) ? MAP_MAX : MAX_COLUMNS;
    localparam int ROWS_CLIP = (MAX_ROWS > MAP_MAX) ? MAP_MAX : MAX_ROWS;

    // captured request
    logic [REQ_W-1:0]         req_reg;
    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [CATEGORY_BITS-1:0] cat_reg;
    logic                     repl_reg;
    logic [SIZE_W-1:0]        bw_reg;
    logic [SIZE_W-1:0]        bh_reg;

    // box walk
    logic [COL_W-1:0] wc_reg;
    logic [ROW_W-1:0] wr_reg;
    logic [PIX_W-1:0] bx_reg;
    logic [PIX_W-1:0] sx_reg;
    logic [PIX_W-1:0] sy_reg;
    logic [PIX_W-1:0] ex_reg;
    logic [PIX_W-1:0] ey_reg;

    // clearing sweep
    logic [AW-1:0] clr_cnt_reg;

    // result and output
    logic             res_free_reg;
    logic             res_marked_reg;
    logic [CAT_W-1:0] res_cat_reg;
    logic             out_valid_reg;
    logic             out_free_reg;
    logic             out_marked_reg;
    logic [CAT_W-1:0] out_cat_reg;

    // memory port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [MEM_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [MEM_W-1:0] ram_rdata;

    logic [MAP_W-1:0]         cols_use;
    logic [MAP_W-1:0]         rows_use;
    logic [CELL_W_W-1:0]      gw;
    logic [CELL_W_W-1:0]      gh;
    logic [AW-1:0]            target_addr;
    logic [AW-1:0]            walk_addr;
    logic                     rd_mark;
    logic [CATEGORY_BITS-1:0] rd_cat;
    logic [CATEGORY_BITS-1:0] new_cat;
    logic [COL_W:0]           col_next;
    logic [ROW_W:0]           row_next;
    logic [PIX_W-1:0]         sx_next;
    logic [PIX_W-1:0]         sy_next;
    logic                     col_more;
    logic                     row_more;

    function automatic logic [AW-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                input logic [ROW_W-1:0] r);
        int lin;
        lin = int'(r) * MAX_COLUMNS + int'(c);
        return AW'(lin);
    endfunction

    // map limits and effective cell size
    assign cols_use = (cfg.map_columns < MAP_W'(COLS_CLIP)) ? cfg.map_columns
                                                            : MAP_W'(COLS_CLIP);
    assign rows_use = (cfg.map_rows < MAP_W'(ROWS_CLIP)) ? cfg.map_rows
                                                         : MAP_W'(ROWS_CLIP);
    assign gw = (cfg.cell_width == '0) ? CELL_W_W'(1) : cfg.cell_width;
    assign gh = (cfg.cell_height == '0) ? CELL_W_W'(1) : cfg.cell_height;

    assign target_addr = cell_addr(col_reg, row_reg);
    assign walk_addr   = cell_addr(wc_reg, wr_reg);

    // memory entry fields and mark merge
    assign rd_mark = ram_rdata[MEM_W-1];
    assign rd_cat  = ram_rdata[CATEGORY_BITS-1:0];
    assign new_cat = repl_reg ? cat_reg : (rd_mark ? (rd_cat | cat_reg) : cat_reg);

    // walk step: next column, or the box's first column in the next row
    assign col_next = {1'b0, wc_reg} + (COL_W + 1)'(1);
    assign row_next = {1'b0, wr_reg} + (ROW_W + 1)'(1);
    assign sx_next  = sx_reg + PIX_W'(gw);
    assign sy_next  = sy_reg + PIX_W'(gh);
    assign col_more = (col_next < (COL_W + 1)'(cols_use)) && (sx_next <= ex_reg);
    assign row_more = (row_next < (ROW_W + 1)'(rows_use)) && (sy_next <= ey_reg);

    // status to the controller
    always_comb
    begin
        stat.req       = req_type_t'(req_reg);
        stat.in_map    = (col_reg < cols_use) && (row_reg < rows_use);
        stat.small_box = (bw_reg <= SIZE_W'(1)) || (bh_reg <= SIZE_W'(1));
        stat.rd_marked = rd_mark;
        stat.clr_last  = (clr_cnt_reg == AW'(DEPTH - 1));
        stat.col_more  = col_more;
        stat.row_more  = row_more;
        stat.out_free  = !out_valid_reg || m_tready;
    end

    // memory address and write data
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = target_addr;
        ram_wdata = '0;
        ram_raddr = cmd.box_rd ? walk_addr : target_addr;
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (cmd.wr_del)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.wr_mark)
        begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, new_cat};
        end
    end

    ogrc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            col_reg  <= cell_col;
            row_reg  <= cell_row;
            cat_reg  <= CATEGORY_BITS'(category);
            repl_reg <= replace_category;
            bw_reg   <= box_width;
            bh_reg   <= box_height;
        end
    end

    // box start pixels, end pixels and walk
    always_ff @(posedge clk)
    begin
        if (cmd.box_mul)
        begin
            bx_reg <= PIX_W'(col_reg) * PIX_W'(gw);
            sx_reg <= PIX_W'(col_reg) * PIX_W'(gw);
            sy_reg <= PIX_W'(row_reg) * PIX_W'(gh);
            wc_reg <= col_reg;
            wr_reg <= row_reg;
        end
        else if (cmd.box_adv)
        begin
            if (col_more)
            begin
                wc_reg <= col_next[COL_W-1:0];
                sx_reg <= sx_next;
            end
            else
            begin
                wc_reg <= col_reg;
                sx_reg <= bx_reg;
                wr_reg <= row_next[ROW_W-1:0];
                sy_reg <= sy_next;
            end
        end
        if (cmd.box_end)
        begin
            ex_reg <= sx_reg + PIX_W'(gw >> 1) + PIX_W'(bw_reg) - PIX_W'(1);
            ey_reg <= sy_reg + PIX_W'(gh >> 1) + PIX_W'(bh_reg) - PIX_W'(1);
        end
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    // result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_free_reg   <= 1'b0;
            res_marked_reg <= 1'b0;
            res_cat_reg    <= '0;
        end
        else
        begin
            if (cmd.set_free)
            begin
                res_free_reg <= 1'b1;
            end
            if (cmd.set_cell_res)
            begin
                res_marked_reg <= rd_mark;
                res_cat_reg    <= rd_mark ? CAT_W'(rd_cat) : '0;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_free_reg   <= res_free_reg;
            out_marked_reg <= res_marked_reg;
            out_cat_reg    <= res_cat_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign is_free         = out_free_reg;
    assign is_marked       = out_marked_reg;
    assign stored_category = out_cat_reg;

endmodule

>>> hw/rtl/occupancy_grid_region_check_core.sv
// ----------------------------------------------------------------------------
// occupancy_grid_region_check_core
// Occupancy grid with per-cell obstacle mark and category word, answering
// cell and box collision queries.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream (request code in s_tuser, operands in
// s_tdata); every request yields exactly one result transfer on the m_ stream.
// Cell size and map size are set through the APB-style register port while
// no request is in flight.
// Steps from the accepted request to its result (an off-map target, unknown
// request or small box goes straight to the result):
//   mark, cell query    memory read, then write back or result capture
//   delete              write back of an empty entry
//   box query           box bounds, one registered memory read per covered
//                       cell visited; stops at the first marked cell
//   clear all           one grid entry per cycle
// A new request is taken only after the previous one has reached the output
// register, so requests are handled one at a time.
// Reset runs the same clearing sweep over all MAX_COLUMNS*MAX_ROWS entries
// (4096 by default), with s_tready low; register writes are taken meanwhile.
// When the receiver stalls, the result waits in the output register; the
// next request may still be accepted and worked on, and its result is held
// until the output register is free.
// ----------------------------------------------------------------------------
module occupancy_grid_region_check_core #(
    parameter int MAX_COLUMNS   = ogrc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = ogrc_pkg::DEF_MAX_ROWS,
    parameter int CATEGORY_BITS = ogrc_pkg::DEF_CATEGORY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cell_col[6:0], cell_row[13:7], category[29:14], replace_category[30],
    // box_width[42:31], box_height[54:43], zero[55]
    input  logic [ogrc_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [ogrc_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // is_free[0], is_marked[1], stored_category[17:2], zero[23:18]
    output logic [ogrc_pkg::M_TDATA_W-1:0]  m_tdata,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ogrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ogrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ogrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    import ogrc_pkg::*;

    cfg_t             cfg;
    cmd_t             cmd;
    stat_t            stat;
    logic             is_free;
    logic             is_marked;
    logic [CAT_W-1:0] stored_category;

    // configuration registers
    ogrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // request sequencer
    ogrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // grid datapath, operands unpacked from the request transfer
    ogrc_dp #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .CATEGORY_BITS (CATEGORY_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .req_type         (s_tuser[REQ_W-1:0]),
        .cell_col         (s_tdata[6:0]),
        .cell_row         (s_tdata[13:7]),
        .category         (s_tdata[29:14]),
        .replace_category (s_tdata[30]),
        .box_width        (s_tdata[42:31]),
        .box_height       (s_tdata[54:43]),
        .cmd              (cmd),
        .stat             (stat),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .is_free          (is_free),
        .is_marked        (is_marked),
        .stored_category  (stored_category)
    );

    // result packing
    assign m_tdata = {(M_TDATA_W - CAT_W - 2)'(0), stored_category, is_marked, is_free};

endmodule
